// ===== sv/tee_pkg.sv =====
// Shared types, mode codes and character constants for the text escape encoder.
`default_nettype none

package tee_pkg;

   localparam int unsigned MAX_LEN = 6;

   localparam logic [2:0] MODE_JSON  = 3'd0;
   localparam logic [2:0] MODE_AJSON = 3'd1;
   localparam logic [2:0] MODE_URL   = 3'd2;
   localparam logic [2:0] MODE_JS    = 3'd3;
   localparam logic [2:0] MODE_NAME  = 3'd4;
   localparam logic [2:0] MODE_HTML  = 3'd5;

   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_APOS    = 8'h27;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PCT     = 8'h25;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DEL     = 8'h7F;

   typedef logic [MAX_LEN-1:0][7:0] text_type;

   typedef struct packed {
      text_type   text;
      logic [2:0] count;
      logic       ends;
   } exp_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {4'd0, nib};
      end else begin
         c = 8'h57 + {4'd0, nib};
      end
      return c;
   endfunction

   function automatic logic [7:0] lower(input logic [7:0] c);
      return c | 8'h20;
   endfunction

endpackage

`default_nettype wire

// ===== sv/text_escape_encoder.sv =====
// Top level of the text escape encoder: mode register, expansion buffer, byte sequencer.
//
//  channel | direction | ports                                      | handshake
//  req     | in        | req_in_byte, req_last_in_string            | req_valid / req_stall
//  rsp     | out       | rsp_out_byte, rsp_last_of_item             | rsp_valid / rsp_stall
//  csr     | in        | csr_wr_data (escape mode)                  | csr_wr_en
//
// A request transaction is expanded in the cycle it is accepted and held in a six-byte buffer.
// The buffer emits one byte per cycle unless rsp_stall is high; a transaction of n bytes holds
// it until its last byte leaves, so single-byte transactions stream at one per cycle while the
// output is not stalled, and expansions stall the request side. The next request is accepted
// in the same cycle the last byte of the previous one leaves. Transactions giving no bytes
// leave the buffer idle. Reset clears mode, buffer control state and the string-ended flag.
`default_nettype none

module text_escape_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_last_in_string,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_item,
   input  wire logic       csr_wr_en,
   input  wire logic [2:0] csr_wr_data
);
   import tee_pkg::*;

   logic [2:0] mode_ff;
   logic       ended_ff, ended_in;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] cnt_ff, cnt_in;
   text_type   text_ff, text_in;
   exp_type    exp;
   logic       is_last;
   logic       rsp_take;
   logic       req_take;

   tee_expand u_expand (
      .in_byte (req_in_byte),
      .mode    (mode_ff),
      .ended   (ended_ff),
      .exp     (exp)
   );

   assign is_last          = idx_ff == (cnt_ff - 3'd1);
   assign rsp_take         = busy_ff && !rsp_stall;
   assign req_stall        = busy_ff && !(rsp_take && is_last);
   assign req_take         = req_valid && !req_stall;
   assign rsp_valid        = busy_ff;
   assign rsp_out_byte     = text_ff[idx_ff];
   assign rsp_last_of_item = is_last;

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      text_in  = text_ff;
      ended_in = ended_ff;
      if (req_take) begin
         busy_in  = exp.count != 3'd0;
         idx_in   = 3'd0;
         cnt_in   = exp.count;
         text_in  = exp.text;
         ended_in = (ended_ff || exp.ends) && !req_last_in_string;
      end else if (rsp_take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_JSON;
         ended_ff <= 1'b0;
         busy_ff  <= 1'b0;
         idx_ff   <= 3'd0;
         cnt_ff   <= 3'd0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         ended_ff <= ended_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      text_ff <= text_in;
   end

endmodule

`default_nettype wire

// ===== sv/tee_expand.sv =====
// Combinational expansion of one input byte into its escaped text.
`default_nettype none

module tee_expand (
   input  wire logic [7:0]      in_byte,
   input  wire logic [2:0]      mode,
   input  wire logic            ended,
   output tee_pkg::exp_type     exp
);
   import tee_pkg::*;

   logic       is_alnum;
   logic       hund_two;
   logic [6:0] rem;
   logic [14:0] prod;
   logic [3:0] tens;
   logic [6:0] tens_x10;
   logic [3:0] units;
   logic [7:0] two;
   logic [7:0] h_hi;
   logic [7:0] h_lo;

   always_comb begin
      is_alnum = (in_byte >= 8'h30 && in_byte <= 8'h39) ||
                 (lower(in_byte) >= 8'h61 && lower(in_byte) <= 8'h7A);
      hund_two = in_byte >= 8'd200;
      rem      = hund_two ? 7'(in_byte - 8'd200) : 7'(in_byte - 8'd100);
      prod     = 15'(rem) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = {tens, 3'b000} - 7'(tens) - 7'(tens) + 7'({tens, 2'b00});
      units    = 4'(rem - tens_x10);
      h_hi     = hex_char(in_byte[7:4]);
      h_lo     = hex_char(in_byte[3:0]);
      unique case (in_byte)
         8'd8:      two = "b";
         8'd9:      two = "t";
         8'd10:     two = "n";
         8'd12:     two = "f";
         8'd13:     two = "r";
         CH_QUOTE:  two = CH_QUOTE;
         CH_BSLASH: two = CH_BSLASH;
         CH_SLASH:  two = CH_SLASH;
         default:   two = 8'd0;
      endcase
   end

   always_comb begin
      exp.text    = '0;
      exp.text[0] = in_byte;
      exp.count   = 3'd1;
      exp.ends    = 1'b0;
      if (ended) begin
         exp.count = 3'd0;
      end else begin
         unique case (mode)
            MODE_JSON, MODE_AJSON: begin
               priority if (two != 8'd0) begin
                  exp.text[0] = CH_BSLASH;
                  exp.text[1] = two;
                  exp.count   = 3'd2;
               end else if (in_byte < CH_SPACE || (mode == MODE_AJSON && in_byte[7])) begin
                  exp.text[0] = CH_BSLASH;
                  exp.text[1] = "u";
                  exp.text[2] = CH_ZERO;
                  exp.text[3] = CH_ZERO;
                  exp.text[4] = h_hi;
                  exp.text[5] = h_lo;
                  exp.count   = 3'd6;
               end else begin
                  exp.count = 3'd1;
               end
            end
            MODE_URL, MODE_JS: begin
               if ((mode == MODE_URL && !is_alnum) ||
                   (mode == MODE_JS && (in_byte < CH_SPACE || in_byte >= CH_DEL ||
                    in_byte == CH_PCT || in_byte == CH_APOS || in_byte == CH_COMMA ||
                    in_byte == CH_SEMI || in_byte == CH_QUOTE))) begin
                  exp.text[0] = CH_PCT;
                  exp.text[1] = h_hi;
                  exp.text[2] = h_lo;
                  exp.count   = 3'd3;
               end
            end
            MODE_NAME: begin
               priority if (in_byte == 8'd0) begin
                  exp.count = 3'd0;
                  exp.ends  = 1'b1;
               end else if (in_byte <= CH_SPACE || in_byte == CH_DEL ||
                            in_byte == CH_APOS || in_byte == CH_COMMA) begin
                  exp.text[0] = CH_UNDER;
               end else begin
                  exp.count = 3'd1;
               end
            end
            MODE_HTML: begin
               priority if (in_byte[7]) begin
                  exp.text[0] = CH_AMP;
                  exp.text[1] = CH_HASH;
                  exp.text[2] = hund_two ? 8'h32 : 8'h31;
                  exp.text[3] = CH_ZERO + {4'd0, tens};
                  exp.text[4] = CH_ZERO + {4'd0, units};
                  exp.text[5] = CH_SEMI;
                  exp.count   = 3'd6;
               end else if (in_byte == CH_LT || in_byte == CH_GT) begin
                  exp.text[0] = CH_AMP;
                  exp.text[1] = (in_byte == CH_LT) ? "l" : "g";
                  exp.text[2] = "t";
                  exp.text[3] = CH_SEMI;
                  exp.count   = 3'd4;
               end else if (in_byte == CH_AMP) begin
                  exp.text[0] = CH_AMP;
                  exp.text[1] = "a";
                  exp.text[2] = "m";
                  exp.text[3] = "p";
                  exp.text[4] = CH_SEMI;
                  exp.count   = 3'd5;
               end else if (in_byte == CH_QUOTE) begin
                  exp.text[0] = CH_AMP;
                  exp.text[1] = "q";
                  exp.text[2] = "u";
                  exp.text[3] = "o";
                  exp.text[4] = "t";
                  exp.text[5] = CH_SEMI;
                  exp.count   = 3'd6;
               end else if ((in_byte < CH_SPACE && in_byte != 8'd10 && in_byte != 8'd13) ||
                            in_byte == CH_DEL) begin
                  exp.text[0] = CH_DOT;
               end else begin
                  exp.count = 3'd1;
               end
            end
            default: begin
               exp.count = 3'd1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
